@@ rtl/core/clut_pkg.sv @@
// ----------------------------------------------------------------------------
// clut_pkg
// Shared types and constants of the trilinear 3d color lookup core.
// ----------------------------------------------------------------------------
package clut_pkg;

    localparam int unsigned MAX_GRID_POINTS = 33;
    localparam int unsigned OUT_CHANNELS    = 4;
    localparam int unsigned NUM_CORNERS     = 8;
    localparam int unsigned STORE_DEPTH     = MAX_GRID_POINTS * MAX_GRID_POINTS
                                              * MAX_GRID_POINTS;
    localparam int unsigned ADDR_W          = $clog2(STORE_DEPTH);
    localparam int unsigned WORD_W          = 32;

    localparam logic [3:0]  SHIFT_TOP       = 4'd8;
    localparam logic [3:0]  SHIFT_MIN       = 4'd3;
    localparam logic [3:0]  SHIFT_RESET     = 4'd4;

    localparam logic        OP_WRITE        = 1'b0;
    localparam logic        OP_PIXEL        = 1'b1;

    localparam logic [0:0]  REG_GRID_SHIFT  = 1'b0;

    typedef struct packed {
        logic        operation;
        logic [15:0] table_address;
        logic [31:0] table_word;
        logic [7:0]  in_c;
        logic [7:0]  in_m;
        logic [7:0]  in_y;
        logic        last_pixel;
    } px_t;

    typedef struct packed {
        logic [7:0] out_ch0;
        logic [7:0] out_ch1;
        logic [7:0] out_ch2;
        logic [7:0] out_ch3;
        logic       last_out;
    } res_t;

endpackage

@@ rtl/core/color_lut_trilinear_3in_4out_core.sv @@
// ----------------------------------------------------------------------------
// color_lut_trilinear_3in_4out_core
// 3d lookup table color converter with trilinear interpolation.
// ----------------------------------------------------------------------------
// result path: a pixel passes the stage 1 to stage 4 registers, then the output register
// throughput: one item per cycle while res_stall does not hold the output; the table is
//   held in eight copies, one read port per cell corner, all written by the same table write
// reset: grid_shift returns to 4, pipeline valids clear; table contents stay
//   undefined until written, no clearing pass
module color_lut_trilinear_3in_4out_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                px_valid,
    output logic                px_stall,
    input  clut_pkg::px_t       px_data,
    output logic                res_valid,
    input  logic                res_stall,
    output clut_pkg::res_t      res_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [0:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int unsigned NC = clut_pkg::NUM_CORNERS;
    localparam int unsigned AW = clut_pkg::ADDR_W;

    // config register
    logic [3:0] grid_shift_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == clut_pkg::REG_GRID_SHIFT) ? {28'd0, grid_shift_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_shift_reg <= clut_pkg::SHIFT_RESET;
        end
        else if (psel && penable && pwrite && paddr == clut_pkg::REG_GRID_SHIFT)
        begin
            grid_shift_reg <= pwdata[3:0];
        end
    end

    // effective shift
    logic [3:0] eff_shift;
    always_comb
    begin
        eff_shift = grid_shift_reg;
        if (eff_shift > clut_pkg::SHIFT_TOP)
        begin
            eff_shift = clut_pkg::SHIFT_TOP;
        end
        if (eff_shift < clut_pkg::SHIFT_MIN)
        begin
            eff_shift = clut_pkg::SHIFT_MIN;
        end
    end

    // stage enables
    logic res_valid_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en_out, en4, en3, en2, en1;

    assign en_out   = !res_valid_reg || !res_stall;
    assign en4      = !v4_reg || en_out;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign px_stall = !en1;

    // stage 1: cell index and fraction
    logic             op1_reg;
    logic [15:0]      waddr1_reg;
    logic [31:0]      wword1_reg;
    logic [3:0]       s1_reg;
    logic [5:0]       g1_reg;
    logic [10:0]      gg1_reg;
    logic [5:0]       idx1_reg [3];
    logic [7:0]       frac1_reg [3];
    logic             last1_reg;

    logic [5:0]       g_next;
    logic [7:0]       mask_next;
    logic [7:0]       comp_next [3];

    always_comb
    begin
        g_next       = 6'(9'(9'd256 >> eff_shift) + 9'd1);
        mask_next    = 8'(9'(9'd1 << eff_shift) - 9'd1);
        comp_next[0] = px_data.in_c;
        comp_next[1] = px_data.in_m;
        comp_next[2] = px_data.in_y;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg    <= px_data.operation;
            waddr1_reg <= px_data.table_address;
            wword1_reg <= px_data.table_word;
            s1_reg     <= eff_shift;
            g1_reg     <= g_next;
            gg1_reg    <= 11'(g_next * g_next);
            last1_reg  <= px_data.last_pixel;
            for (int a = 0; a < 3; a++)
            begin
                idx1_reg[a]  <= 6'(comp_next[a] >> eff_shift);
                frac1_reg[a] <= comp_next[a] & mask_next;
            end
        end
    end

    // stage 2: corner addresses and partial weights
    logic             op2_reg;
    logic [15:0]      waddr2_reg;
    logic [31:0]      wword2_reg;
    logic [3:0]       s2_reg;
    logic             last2_reg;
    logic [AW-1:0]    addr2_reg [NC];
    logic [17:0]      wcm2_reg [4];
    logic [8:0]       fy2_reg [2];

    logic [8:0]       step1;
    logic [8:0]       fac1 [3][2];

    always_comb
    begin
        step1 = 9'(9'd1 << s1_reg);
        for (int a = 0; a < 3; a++)
        begin
            fac1[a][0] = step1 - {1'b0, frac1_reg[a]};
            fac1[a][1] = {1'b0, frac1_reg[a]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            op2_reg    <= op1_reg;
            waddr2_reg <= waddr1_reg;
            wword2_reg <= wword1_reg;
            s2_reg     <= s1_reg;
            last2_reg  <= last1_reg;
            for (int k = 0; k < NC; k++)
            begin
                addr2_reg[k] <= AW'(
                    17'(6'(idx1_reg[0] + 6'((k >> 2) & 1)) * gg1_reg)
                    + 17'(6'(idx1_reg[1] + 6'((k >> 1) & 1)) * g1_reg)
                    + 17'(6'(idx1_reg[2] + 6'(k & 1))));
            end
            for (int j = 0; j < 4; j++)
            begin
                wcm2_reg[j] <= fac1[0][(j >> 1) & 1] * fac1[1][j & 1];
            end
            fy2_reg[0] <= fac1[2][0];
            fy2_reg[1] <= fac1[2][1];
        end
    end

    // stage 3: table read and full corner weights
    logic             write_en;
    logic [31:0]      rd3_reg [NC];
    logic [24:0]      w3_reg [NC];
    logic [3:0]       s3_reg;
    logic             last3_reg;

    assign write_en = en3 && v2_reg && (op2_reg == clut_pkg::OP_WRITE)
                      && (32'(waddr2_reg) < clut_pkg::STORE_DEPTH);

    for (genvar k = 0; k < NC; k++)
    begin : g_bank
        logic [clut_pkg::WORD_W-1:0] mem [clut_pkg::STORE_DEPTH];

        always_ff @(posedge clk)
        begin
            if (write_en)
            begin
                mem[waddr2_reg[AW-1:0]] <= wword2_reg;
            end
            if (en3)
            begin
                rd3_reg[k] <= mem[addr2_reg[k]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_reg    <= s2_reg;
            last3_reg <= last2_reg;
            for (int k = 0; k < NC; k++)
            begin
                w3_reg[k] <= 25'(wcm2_reg[(k >> 1) & 3] * fy2_reg[k & 1]);
            end
        end
    end

    // stage 4: channel products
    logic [31:0]      prod4_reg [clut_pkg::OUT_CHANNELS][NC];
    logic [3:0]       s4_reg;
    logic             last4_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_reg    <= s3_reg;
            last4_reg <= last3_reg;
            for (int ch = 0; ch < clut_pkg::OUT_CHANNELS; ch++)
            begin
                for (int k = 0; k < NC; k++)
                begin
                    prod4_reg[ch][k] <= 32'(rd3_reg[k][8*ch +: 8] * w3_reg[k]);
                end
            end
        end
    end

    // stage 5: sum, scale, output register
    logic [7:0]       ch_next [clut_pkg::OUT_CHANNELS];
    logic [31:0]      sum4 [clut_pkg::OUT_CHANNELS];
    logic [4:0]       sh4;
    clut_pkg::res_t   res_reg;

    always_comb
    begin
        sh4 = 5'(6'(s4_reg) * 6'd3);
        for (int ch = 0; ch < clut_pkg::OUT_CHANNELS; ch++)
        begin
            sum4[ch] = 32'd0;
            for (int k = 0; k < NC; k++)
            begin
                sum4[ch] = sum4[ch] + prod4_reg[ch][k];
            end
            ch_next[ch] = 8'(sum4[ch] >> sh4);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && v4_reg)
        begin
            res_reg.out_ch0  <= ch_next[0];
            res_reg.out_ch1  <= ch_next[1];
            res_reg.out_ch2  <= ch_next[2];
            res_reg.out_ch3  <= ch_next[3];
            res_reg.last_out <= last4_reg;
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= px_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg && (op2_reg == clut_pkg::OP_PIXEL);
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en_out)
            begin
                res_valid_reg <= v4_reg;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the trilinear 3d color lookup core against an in-bench predictor.
// Table writes and pixels flow through the input channel with random gaps and
// output stalls. Each pixel's corners are loaded before the pixel is sent.
// Every result is compared field by field with the predicted one.
// ----------------------------------------------------------------------------
module testbench;

    import clut_pkg::*;

    localparam int unsigned DEPTH = MAX_GRID_POINTS * MAX_GRID_POINTS * MAX_GRID_POINTS;
    localparam int unsigned CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        px_valid;
    logic        px_stall;
    px_t         px_data;
    logic        res_valid;
    logic        res_stall;
    res_t        res_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    px_t         pending_q[$];
    res_t        color_q[$];
    logic [31:0] lut_copy [0:DEPTH-1];
    bit          loaded [0:DEPTH-1];
    logic [3:0]  shift_reg;
    int unsigned queued_cnt;
    int unsigned taken_cnt;
    int unsigned cycle_cnt;
    int unsigned errors;
    bit          no_idle;
    bit          hold_go;
    bit          was_taken;
    int unsigned gap_cnt;
    int unsigned stall_cnt;
    int unsigned hold_cnt;

    color_lut_trilinear_3in_4out_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .px_valid  (px_valid),
        .px_stall  (px_stall),
        .px_data   (px_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int unsigned grid_step_log(logic [3:0] r);
        int unsigned s;
        s = r;
        if (s > SHIFT_TOP)
            s = SHIFT_TOP;
        while (s < SHIFT_TOP && ((256 >> s) + 1) > MAX_GRID_POINTS)
            s++;
        return s;
    endfunction

    function automatic int unsigned corner_addr(logic [7:0] c, logic [7:0] m, logic [7:0] y,
                                                int unsigned s, int unsigned k);
        int unsigned g;
        g = (256 >> s) + 1;
        return ((c >> s) + ((k >> 2) & 1)) * g * g + ((m >> s) + ((k >> 1) & 1)) * g
               + (y >> s) + (k & 1);
    endfunction

    function automatic res_t interpolate(px_t p);
        res_t        r;
        int unsigned s;
        int unsigned step;
        int unsigned f [3];
        longint unsigned acc [4];
        longint unsigned w;
        logic [31:0] word;
        logic [7:0]  comp [3];
        comp[0] = p.in_c;
        comp[1] = p.in_m;
        comp[2] = p.in_y;
        s = grid_step_log(shift_reg);
        step = 1 << s;
        for (int a = 0; a < 3; a++)
            f[a] = comp[a] & (step - 1);
        for (int ch = 0; ch < 4; ch++)
            acc[ch] = 0;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            w = 1;
            for (int a = 0; a < 3; a++)
                w = w * (((k >> (2 - a)) & 1) ? f[a] : step - f[a]);
            word = lut_copy[corner_addr(p.in_c, p.in_m, p.in_y, s, k)];
            for (int ch = 0; ch < 4; ch++)
                acc[ch] += longint'(word[8*ch +: 8]) * w;
        end
        r.out_ch0  = 8'(acc[0] >> (3 * s));
        r.out_ch1  = 8'(acc[1] >> (3 * s));
        r.out_ch2  = 8'(acc[2] >> (3 * s));
        r.out_ch3  = 8'(acc[3] >> (3 * s));
        r.last_out = p.last_pixel;
        return r;
    endfunction

    task automatic push_write(int unsigned addr, logic [31:0] word);
        px_t p;
        p.operation     = OP_WRITE;
        p.table_address = 16'(addr);
        p.table_word    = word;
        p.in_c          = 8'($urandom);
        p.in_m          = 8'($urandom);
        p.in_y          = 8'($urandom);
        p.last_pixel    = 1'($urandom);
        if (addr < DEPTH)
            loaded[addr] = 1'b1;
        pending_q.push_back(p);
        queued_cnt++;
    endtask

    task automatic push_pixel(logic [7:0] c, logic [7:0] m, logic [7:0] y, logic last);
        px_t         p;
        int unsigned a;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            a = corner_addr(c, m, y, grid_step_log(shift_reg), k);
            if (!loaded[a])
                push_write(a, $urandom);
        end
        p.operation     = OP_PIXEL;
        p.table_address = 16'($urandom);
        p.table_word    = $urandom;
        p.in_c          = c;
        p.in_m          = m;
        p.in_y          = y;
        p.last_pixel    = last;
        pending_q.push_back(p);
        queued_cnt++;
    endtask

    function automatic logic [7:0] pick_comp();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_random(int unsigned n);
        int unsigned sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 80)
                push_pixel(pick_comp(), pick_comp(), pick_comp(), 1'($urandom));
            else if (sel < 95)
                push_write($urandom_range(0, DEPTH - 1), $urandom);
            else
                push_write($urandom_range(DEPTH, 65535), $urandom);
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (taken_cnt != queued_cnt || color_q.size() != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic apb_write(logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= REG_GRID_SHIFT;
        pwdata  <= value;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        shift_reg = value[3:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n && px_valid && !px_stall)
        begin
            was_taken = 1'b1;
            taken_cnt++;
            if (px_data.operation == OP_WRITE)
            begin
                if (px_data.table_address < DEPTH)
                    lut_copy[px_data.table_address] = px_data.table_word;
            end
            else
                color_q.push_back(interpolate(px_data));
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!px_valid || was_taken))
        begin
            was_taken = 1'b0;
            if (gap_cnt > 0)
            begin
                gap_cnt--;
                px_valid <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                gap_cnt = $urandom_range(0, 12);
                px_valid <= 1'b0;
            end
            else if (pending_q.size() != 0)
            begin
                px_data  <= pending_q.pop_front();
                px_valid <= 1'b1;
            end
            else
                px_valid <= 1'b0;
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_go && hold_cnt == 0)
            begin
                hold_go  = 1'b0;
                hold_cnt = 120;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                res_stall <= 1'b1;
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt--;
                res_stall <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                stall_cnt = $urandom_range(0, 12);
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        res_t want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        if (rst_n && res_valid && !res_stall)
        begin
            if (color_q.size() == 0)
            begin
                $display("%0t unexpected transfer: exp none got %h", $time, res_data);
                errors++;
            end
            else
            begin
                want = color_q.pop_front();
                if (res_data.out_ch0 !== want.out_ch0)
                begin
                    $display("%0t out_ch0 exp %h got %h", $time, want.out_ch0, res_data.out_ch0);
                    errors++;
                end
                if (res_data.out_ch1 !== want.out_ch1)
                begin
                    $display("%0t out_ch1 exp %h got %h", $time, want.out_ch1, res_data.out_ch1);
                    errors++;
                end
                if (res_data.out_ch2 !== want.out_ch2)
                begin
                    $display("%0t out_ch2 exp %h got %h", $time, want.out_ch2, res_data.out_ch2);
                    errors++;
                end
                if (res_data.out_ch3 !== want.out_ch3)
                begin
                    $display("%0t out_ch3 exp %h got %h", $time, want.out_ch3, res_data.out_ch3);
                    errors++;
                end
                if (res_data.last_out !== want.last_out)
                begin
                    $display("%0t last_out exp %h got %h", $time, want.last_out,
                             res_data.last_out);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        logic [3:0] shifts [9];
        shifts = '{4'd3, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd9, 4'd6, 4'd7};
        rst_n     = 1'b0;
        px_valid  = 1'b0;
        px_data   = '0;
        res_stall = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        shift_reg = SHIFT_RESET;
        errors    = 0;
        cycle_cnt = 0;
        queued_cnt = 0;
        taken_cnt = 0;
        no_idle   = 1'b0;
        hold_go   = 1'b0;
        was_taken = 1'b0;
        gap_cnt   = 0;
        stall_cnt = 0;
        hold_cnt  = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset grid step
        push_write(0, 32'h0000_0000);
        push_write(DEPTH, 32'hffff_ffff);
        push_write(65535, 32'h1234_5678);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        push_write(0, 32'hffff_ffff);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        push_pixel(8'd255, 8'd0, 8'd128, 1'b1);
        push_pixel(8'd15, 8'd16, 8'd17, 1'b0);
        push_pixel(8'd170, 8'd85, 8'd240, 1'b1);
        drain();

        apb_write(32'd3);
        push_write(DEPTH - 1, 32'hffff_ffff);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd248, 8'd7, 8'd255, 1'b0);
        push_pixel(8'd0, 8'd255, 8'd0, 1'b1);
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            apb_write({28'd0, shifts[ph]});
            if (ph == 1)
                hold_go = 1'b1;
            if (ph == 8)
                no_idle = 1'b1;
            push_random(20);
            if (ph == 2)
                drain();
            push_random(20);
            drain();
        end

        apb_write(32'(SHIFT_RESET));
        push_random(30);
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/clut_pkg.sv
rtl/core/color_lut_trilinear_3in_4out_core.sv
tb/testbench.sv
